@@ hw/rtl/heb_pkg.sv @@
package heb_pkg;

   // Sizing of the edge store and the hash table.
   localparam int MAX_EDGES  = 4096;
   localparam int HASH_SLOTS = 8192;

   localparam int EDGE_W    = $clog2(MAX_EDGES);
   localparam int CNT_W     = $clog2(MAX_EDGES + 1);
   localparam int HE_ADDR_W = EDGE_W + 1;
   localparam int HE_DEPTH  = 2 * MAX_EDGES;
   localparam int SLOT_W    = $clog2(HASH_SLOTS);
   localparam int KEY_W     = 64;

   // Fixed field widths of the channels.
   localparam int MODE_W   = 2;
   localparam int VERTEX_W = 32;
   localparam int HE_W     = 13;
   localparam int STATUS_W = 2;

   localparam logic [VERTEX_W-1:0] VERTEX_UNSET = '1;

   // Operation codes.
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [VERTEX_W-1:0] vertex_a;
      logic [VERTEX_W-1:0] vertex_b;
      logic [VERTEX_W-1:0] vertex_c;
      logic [HE_W-1:0]     query_half_edge;
   } req_type;

   typedef struct packed {
      logic [HE_W-1:0]     half_edge;
      logic [HE_W-1:0]     next_half_edge;
      logic [VERTEX_W-1:0] origin_vertex;
      logic                edge_opened;
      logic [HE_W-1:0]     edge_count;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_type;

   // One half-edge record: successor link with its set flag, and origin vertex.
   typedef struct packed {
      logic                 linked;
      logic [HE_ADDR_W-1:0] next;
      logic [VERTEX_W-1:0]  origin;
   } he_entry_type;

   // Folds the sorted vertex pair into a slot number.
   function automatic logic [SLOT_W-1:0] slot_hash(input logic [KEY_W-1:0] key);
      logic [SLOT_W-1:0] h;
      h = '0;
      for (int i = 0; i < KEY_W; i += SLOT_W) begin
         h ^= SLOT_W'(key >> i);
      end
      if (h >= SLOT_W'(HASH_SLOTS) && HASH_SLOTS < (1 << SLOT_W)) begin
         h = h - SLOT_W'(HASH_SLOTS);
      end
      return h;
   endfunction

endpackage

@@ hw/rtl/heb_ram.sv @@
module heb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/halfedge_builder.sv @@
// Half-edge builder: each add request (three vertex ids) looks up its three sides in a
// linear-probing hash table and returns three transfers; a read request returns one,
// and a clear returns none. An add is accepted, then for each side reads the home
// slot and checks it; an occupied slot also has its edge key read and compared, and
// each further probe reads the next slot and then its key, since the slot table and
// the edge key memory are read one after the other. Twin resets for newly opened
// edges, record writes and the three output transfers follow. An add while the edge
// store is flagged full goes straight to its three transfers. After reset and after
// every clear the slot table is zeroed one slot a cycle, and no request is taken
// meanwhile. Once the edge store has overflowed, adds report status 1 and change
// nothing until a clear.
module halfedge_builder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  heb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output heb_pkg::rsp_type rsp_data
);
   import heb_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b00000000001,
      ST_CLEAR    = 11'b00000000010,
      ST_SIDE     = 11'b00000000100,
      ST_SLOT_CHK = 11'b00000001000,
      ST_KEY_CHK  = 11'b00000010000,
      ST_ROLLBACK = 11'b00000100000,
      ST_UNSET    = 11'b00001000000,
      ST_LINK     = 11'b00010000000,
      ST_EMIT     = 11'b00100000000,
      ST_READ     = 11'b01000000000,
      ST_READ_OUT = 11'b10000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           side_ff, side_in, side_next;
   logic [VERTEX_W-1:0]  v_ff [3];
   logic [VERTEX_W-1:0]  v_in [3];
   logic [KEY_W-1:0]     key_ff, key_in, key_cur;
   logic [SLOT_W-1:0]    slot_ff, slot_in, slot_inc;
   logic [SLOT_W-1:0]    probes_ff, probes_in;
   logic [EDGE_W-1:0]    vidx_ff, vidx_in;
   logic [HE_ADDR_W-1:0] loop_ff [3];
   logic [HE_ADDR_W-1:0] loop_in [3];
   logic [2:0]           op_ff, op_in;
   logic [SLOT_W-1:0]    ins_ff [3];
   logic [SLOT_W-1:0]    ins_in [3];
   logic [CNT_W-1:0]     edges_ff, edges_in, saved_ff, saved_in;
   logic                 flag_ff, flag_in, err_ff, err_in;
   logic [SLOT_W-1:0]    clr_ff, clr_in;
   logic [HE_W-1:0]      q_ff, q_in;
   logic                 q_in_range;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free, req_take;
   logic [VERTEX_W-1:0]  vp, vq;

   // Memory ports.
   logic                 slot_we, slot_re;
   logic [SLOT_W-1:0]    slot_waddr, slot_raddr;
   logic [CNT_W-1:0]     slot_wdata, slot_rdata;
   logic                 key_we, key_re;
   logic [EDGE_W-1:0]    key_raddr;
   logic [KEY_W-1:0]     key_rdata;
   logic                 he_we, he_re;
   logic [HE_ADDR_W-1:0] he_waddr;
   he_entry_type         he_wdata, he_rdata;

   heb_ram #(.WIDTH(CNT_W), .DEPTH(HASH_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (slot_re),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   heb_ram #(.WIDTH(KEY_W), .DEPTH(MAX_EDGES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (edges_ff[EDGE_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (key_re),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   heb_ram #(.WIDTH($bits(he_entry_type)), .DEPTH(HE_DEPTH)) u_he_ram (
      .clock   (clock),
      .wr_en   (he_we),
      .wr_addr (he_waddr),
      .wr_data (he_wdata),
      .rd_en   (he_re),
      .rd_addr (q_ff[HE_ADDR_W-1:0]),
      .rd_data (he_rdata)
   );

   // Side operands: the sorted vertex pair forms the edge key.
   assign side_next = (side_ff == 2'd2) ? 2'd0 : side_ff + 2'd1;
   assign vp        = v_ff[side_ff];
   assign vq        = v_ff[side_next];
   assign key_cur   = (vp < vq) ? {vp, vq} : {vq, vp};
   assign slot_inc  = (slot_ff == SLOT_W'(HASH_SLOTS - 1)) ? '0 : slot_ff + 1'b1;

   assign q_in_range = (CNT_W + 1)'(q_ff) < {edges_ff, 1'b0};
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;

   // Sequencer: clear the slot table; for an add probe, commit or roll back, write records, emit; or read a record.
   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      v_in         = v_ff;
      key_in       = key_ff;
      slot_in      = slot_ff;
      probes_in    = probes_ff;
      vidx_in      = vidx_ff;
      loop_in      = loop_ff;
      op_in        = op_ff;
      ins_in       = ins_ff;
      edges_in     = edges_ff;
      saved_in     = saved_ff;
      flag_in      = flag_ff;
      err_in       = err_ff;
      clr_in       = clr_ff;
      q_in         = q_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      slot_we    = 1'b0;
      slot_waddr = slot_ff;
      slot_wdata = '0;
      slot_re    = 1'b0;
      slot_raddr = slot_ff;
      key_we     = 1'b0;
      key_re     = 1'b0;
      key_raddr  = EDGE_W'(slot_rdata - 1'b1);
      he_we      = 1'b0;
      he_waddr   = loop_ff[side_ff];
      he_wdata   = '{linked: 1'b1, next: loop_ff[side_next], origin: vp};
      he_re      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_data.mode)
                  MODE_ADD: begin
                     v_in[0]  = req_data.vertex_a;
                     v_in[1]  = req_data.vertex_b;
                     v_in[2]  = req_data.vertex_c;
                     saved_in = edges_ff;
                     op_in    = '0;
                     side_in  = '0;
                     err_in   = flag_ff;
                     state_in = flag_ff ? ST_EMIT : ST_SIDE;
                  end
                  MODE_READ: begin
                     q_in     = req_data.query_half_edge;
                     state_in = ST_READ;
                  end
                  MODE_CLEAR: begin
                     edges_in = '0;
                     flag_in  = 1'b0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            if (clr_ff == SLOT_W'(HASH_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         // Start a side: read its home slot.
         ST_SIDE: begin
            key_in     = key_cur;
            slot_in    = slot_hash(key_cur);
            slot_raddr = slot_hash(key_cur);
            slot_re    = 1'b1;
            probes_in  = '0;
            state_in   = ST_SLOT_CHK;
         end

         ST_SLOT_CHK: begin
            if (slot_rdata == '0) begin
               if (edges_ff == CNT_W'(MAX_EDGES)) begin
                  side_in  = '0;
                  state_in = ST_ROLLBACK;
               end else begin
                  // Open a new edge in the empty slot.
                  slot_we          = 1'b1;
                  slot_wdata       = edges_ff + 1'b1;
                  key_we           = 1'b1;
                  loop_in[side_ff] = {edges_ff[EDGE_W-1:0], 1'b0};
                  op_in[side_ff]   = 1'b1;
                  ins_in[side_ff]  = slot_ff;
                  edges_in         = edges_ff + 1'b1;
                  side_in          = side_next;
                  state_in         = (side_ff == 2'd2) ? ST_UNSET : ST_SIDE;
               end
            end else begin
               key_re   = 1'b1;
               vidx_in  = key_raddr;
               state_in = ST_KEY_CHK;
            end
         end

         ST_KEY_CHK: begin
            if (key_rdata == key_ff) begin
               loop_in[side_ff] = {vidx_ff, 1'b1};
               side_in          = side_next;
               state_in         = (side_ff == 2'd2) ? ST_UNSET : ST_SIDE;
            end else if (probes_ff == SLOT_W'(HASH_SLOTS - 1)) begin
               side_in  = '0;
               state_in = ST_ROLLBACK;
            end else begin
               probes_in  = probes_ff + 1'b1;
               slot_in    = slot_inc;
               slot_raddr = slot_inc;
               slot_re    = 1'b1;
               state_in   = ST_SLOT_CHK;
            end
         end

         // Empty the slots that this triangle filled.
         ST_ROLLBACK: begin
            slot_we    = op_ff[side_ff];
            slot_waddr = ins_ff[side_ff];
            side_in    = side_next;
            if (side_ff == 2'd2) begin
               edges_in = saved_ff;
               flag_in  = 1'b1;
               err_in   = 1'b1;
               state_in = ST_EMIT;
            end
         end

         // Mark the twin of each new half-edge as unset.
         ST_UNSET: begin
            he_we    = op_ff[side_ff];
            he_waddr = loop_ff[side_ff] | HE_ADDR_W'(1);
            he_wdata = '{linked: 1'b0, next: '0, origin: VERTEX_UNSET};
            side_in  = side_next;
            if (side_ff == 2'd2) begin
               state_in = ST_LINK;
            end
         end

         // Write successor and origin in side order.
         ST_LINK: begin
            he_we   = 1'b1;
            side_in = side_next;
            if (side_ff == 2'd2) begin
               err_in   = 1'b0;
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.edge_count = HE_W'(edges_ff);
               rsp_in.last       = (side_ff == 2'd2);
               if (err_ff) begin
                  rsp_in.half_edge      = '0;
                  rsp_in.next_half_edge = '0;
                  rsp_in.origin_vertex  = VERTEX_UNSET;
                  rsp_in.edge_opened    = 1'b0;
                  rsp_in.status         = STATUS_FULL;
               end else begin
                  rsp_in.half_edge      = HE_W'(loop_ff[side_ff]);
                  rsp_in.next_half_edge = HE_W'(loop_ff[side_next]);
                  rsp_in.origin_vertex  = vp;
                  rsp_in.edge_opened    = op_ff[side_ff];
                  rsp_in.status         = STATUS_OK;
               end
               side_in = side_next;
               if (side_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_READ: begin
            he_re    = 1'b1;
            state_in = ST_READ_OUT;
         end

         ST_READ_OUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.half_edge   = q_ff;
               rsp_in.edge_opened = 1'b0;
               rsp_in.edge_count  = HE_W'(edges_ff);
               rsp_in.last        = 1'b1;
               if (q_in_range) begin
                  rsp_in.next_half_edge = he_rdata.linked ? HE_W'(he_rdata.next) : q_ff;
                  rsp_in.origin_vertex  = he_rdata.origin;
                  rsp_in.status         = flag_ff ? STATUS_FULL : STATUS_OK;
               end else begin
                  rsp_in.next_half_edge = '0;
                  rsp_in.origin_vertex  = VERTEX_UNSET;
                  rsp_in.status         = STATUS_RANGE;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         edges_ff     <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         edges_ff     <= edges_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      side_ff   <= side_in;
      v_ff      <= v_in;
      key_ff    <= key_in;
      slot_ff   <= slot_in;
      probes_ff <= probes_in;
      vidx_ff   <= vidx_in;
      loop_ff   <= loop_in;
      op_ff     <= op_in;
      ins_ff    <= ins_in;
      saved_ff  <= saved_in;
      err_ff    <= err_in;
      q_ff      <= q_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // The edge count never passes the store size.
   a_edges_bound: assert property (@(posedge clock) disable iff (reset)
      edges_ff <= CNT_W'(MAX_EDGES))
      else $error("edge count above store size");

   // The overflow flag only drops on an accepted clear.
   a_flag_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(flag_ff) |-> ($past(req_take) && $past(req_data.mode) == MODE_CLEAR))
      else $error("overflow flag dropped without a clear");

   // Record writes stay inside the edges held.
   a_link_range: assert property (@(posedge clock) disable iff (reset)
      he_we |-> ((CNT_W + 1)'(he_waddr) < {edges_ff, 1'b0}))
      else $error("half-edge write beyond stored edges");

   // A finished add leaves no transfer pending in the sequencer.
   a_emit_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && rsp_ff.last) |-> (state_ff != ST_EMIT || err_ff
         || side_ff == 2'd0))
      else $error("last transfer while sides remain");
`endif

endmodule
